[rtl/core/sffe_pkg.sv]
// Package of types, constants and codes shared by the sensor frame field extractor.
package sffe_pkg;

  localparam logic [7:0]  PKT_MARKER      = 8'hFF;
  localparam logic [7:0]  KIND_HEADER     = 8'h01;
  localparam logic [7:0]  KIND_DATA       = 8'h03;
  localparam logic [2:0]  SLOT_LAST       = 3'd6;
  localparam logic [2:0]  SLOT_PHASE      = 3'd2;
  localparam logic [2:0]  SLOT_TEMP       = 3'd4;
  localparam logic [2:0]  SLOT_PRES       = 3'd5;
  localparam logic [2:0]  SLOT_ERR        = 3'd6;
  localparam logic [15:0] MEASURE_RESET   = 16'd17;
  localparam logic [15:0] MODE_CODE_RESET = 16'hFFFF;
  localparam logic [7:0]  LEN_DOUBLE      = 8'd8;
  localparam logic [7:0]  LEN_MASK        = 8'd4;
  localparam logic [31:0] MASK_BAD        = 32'hFFFF_FFFF;

  // IEEE double bit patterns.
  localparam logic [63:0] DBL_MINUS_ONE   = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] DBL_QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [10:0] EXP_MAX         = 11'h7FF;
  // 273.15 as a double: exponent and significand with the hidden bit.
  localparam logic [10:0] KELVIN_EXP      = 11'h407;
  localparam logic [52:0] KELVIN_SIG      = 53'h11_1266_6666_6666;
  localparam logic [62:0] KELVIN_MAG      = 63'h4071_1266_6666_6666;

  typedef enum logic [1:0] {
    ACT_PHASE,
    ACT_TEMP,
    ACT_PRES,
    ACT_ERR
  } act_t;

  typedef struct packed {
    logic        valid;
    act_t        act;
    logic [31:0] mask;
  } tag_t;

endpackage

[rtl/core/sffe_if.sv]
// Channel interfaces: packet input, record output and configuration write.
interface sffe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  marker_byte;
  logic [7:0]  kind_byte;
  logic [15:0] response_word;
  logic [63:0] payload;
  logic [7:0]  payload_len;
  modport source (output valid, marker_byte, kind_byte, response_word, payload,
                  payload_len, input ready);
  modport sink (input valid, marker_byte, kind_byte, response_word, payload,
                payload_len, output ready);
endinterface

interface sffe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] phase_value;
  logic [63:0] temperature_c;
  logic [63:0] pressure_pa;
  logic [31:0] error_mask;
  modport source (output valid, phase_value, temperature_c, pressure_pa, error_mask,
                  input ready);
  modport sink (input valid, phase_value, temperature_c, pressure_pa, error_mask,
                output ready);
endinterface

interface sffe_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/core/sffe_fpu.sv]
// Three-stage pipeline computing the phase pass-through, x - 273.15 and x * 100.0.
module sffe_fpu
  import sffe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  tag_t        tag_i,
  input  logic [63:0] x_i,
  output tag_t        tag_o,
  output logic [63:0] res_o
);

  // Stage 2: operand alignment and add, or significand times 25.
  logic        xs;
  logic [10:0] xe;
  logic [51:0] xf;
  logic        x_nan, x_inf, x_zero, x_big;
  logic [52:0] x_m;
  logic [10:0] x_e;
  logic [10:0] e_l, e_s, diff;
  logic [52:0] m_l, m_s;
  logic [5:0]  d6;
  logic [63:0] ext_s, ext_l, sh_s, al_s, asum, msig, xm64;
  logic        lost;
  logic        sp_nxt;
  logic [63:0] spv_nxt, sig_nxt;
  logic        sgn_nxt;
  logic signed [13:0] beb_nxt;

  tag_t        tag2_r;
  logic        sp2_r, sgn2_r;
  logic [63:0] spv2_r, sig2_r;
  logic signed [13:0] beb2_r;

  always_comb begin
    xs     = x_i[63];
    xe     = x_i[62:52];
    xf     = x_i[51:0];
    x_nan  = (xe == EXP_MAX) && (xf != '0);
    x_inf  = (xe == EXP_MAX) && (xf == '0);
    x_zero = (x_i[62:0] == '0);
    x_m    = {(xe != '0), xf};
    x_e    = (xe == '0) ? 11'd1 : xe;
    x_big  = (x_i[62:0] >= KELVIN_MAG);
    e_l    = x_big ? x_e : KELVIN_EXP;
    m_l    = x_big ? x_m : KELVIN_SIG;
    e_s    = x_big ? KELVIN_EXP : x_e;
    m_s    = x_big ? KELVIN_SIG : x_m;
    diff   = e_l - e_s;
    d6     = (diff > 11'd63) ? 6'd63 : diff[5:0];
    ext_s  = {8'b0, m_s, 3'b0};
    ext_l  = {8'b0, m_l, 3'b0};
    sh_s   = ext_s >> d6;
    lost   = |(ext_s & ~({64{1'b1}} << d6));
    al_s   = sh_s | {63'b0, lost};
    // The constant is subtracted, so the operation is a true subtraction for positive x.
    asum   = xs ? (ext_l + al_s) : (ext_l - al_s);
    xm64   = {11'b0, x_m};
    msig   = (xm64 << 4) + (xm64 << 3) + xm64;

    sp_nxt  = 1'b1;
    spv_nxt = x_i;
    sig_nxt = asum;
    sgn_nxt = xs;
    beb_nxt = 14'sd0;
    unique case (tag_i.act)
      ACT_TEMP: begin
        sgn_nxt = x_big ? xs : 1'b1;
        sig_nxt = asum;
        beb_nxt = $signed({3'b0, e_l}) + 14'sd8;
        if (x_nan) begin
          spv_nxt = x_i | DBL_QUIET_BIT;
        end else if (x_inf) begin
          spv_nxt = x_i;
        end else if (asum == '0) begin
          spv_nxt = '0;
        end else begin
          sp_nxt = 1'b0;
        end
      end
      ACT_PRES: begin
        sig_nxt = msig;
        beb_nxt = $signed({3'b0, x_e}) + 14'sd13;
        if (x_nan) begin
          spv_nxt = x_i | DBL_QUIET_BIT;
        end else if (x_inf || x_zero) begin
          spv_nxt = x_i;
        end else begin
          sp_nxt = 1'b0;
        end
      end
      default: begin
        sp_nxt  = 1'b1;
        spv_nxt = x_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r.valid <= 1'b0;
    end else if (en) begin
      tag2_r.valid <= tag_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag2_r.act  <= tag_i.act;
      tag2_r.mask <= tag_i.mask;
      sp2_r       <= sp_nxt;
      spv2_r      <= spv_nxt;
      sig2_r      <= sig_nxt;
      sgn2_r      <= sgn_nxt;
      beb2_r      <= beb_nxt;
    end
  end

  // Stage 3: normalise so that the leading one sits in bit 63.
  logic [63:0] norm_nxt;
  logic [5:0]  lz_nxt;

  always_comb begin
    norm_nxt = sig2_r;
    lz_nxt   = '0;
    if (norm_nxt[63:32] == '0) begin
      norm_nxt  = norm_nxt << 32;
      lz_nxt[5] = 1'b1;
    end
    if (norm_nxt[63:48] == '0) begin
      norm_nxt  = norm_nxt << 16;
      lz_nxt[4] = 1'b1;
    end
    if (norm_nxt[63:56] == '0) begin
      norm_nxt  = norm_nxt << 8;
      lz_nxt[3] = 1'b1;
    end
    if (norm_nxt[63:60] == '0) begin
      norm_nxt  = norm_nxt << 4;
      lz_nxt[2] = 1'b1;
    end
    if (norm_nxt[63:62] == '0) begin
      norm_nxt  = norm_nxt << 2;
      lz_nxt[1] = 1'b1;
    end
    if (norm_nxt[63] == 1'b0) begin
      norm_nxt  = norm_nxt << 1;
      lz_nxt[0] = 1'b1;
    end
  end

  tag_t        tag3_r;
  logic        sp3_r, sgn3_r;
  logic [63:0] spv3_r, norm3_r;
  logic signed [13:0] be3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r.valid <= 1'b0;
    end else if (en) begin
      tag3_r.valid <= tag2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3_r.act  <= tag2_r.act;
      tag3_r.mask <= tag2_r.mask;
      sp3_r       <= sp2_r;
      spv3_r      <= spv2_r;
      sgn3_r      <= sgn2_r;
      norm3_r     <= norm_nxt;
      be3_r       <= beb2_r - $signed({8'b0, lz_nxt});
    end
  end

  // Stage 4: denormalise if needed, round to nearest even and pack.
  logic [13:0] rs_full;
  logic [63:0] ns;
  logic        st, rbit, inc, tiny, ovf;
  logic [52:0] mant;
  logic [10:0] efield;
  logic [63:0] enc;
  logic [63:0] res_nxt;

  always_comb begin
    tiny    = (be3_r < 14'sd1);
    ovf     = (be3_r > 14'sd2046);
    rs_full = 14'd1 - be3_r;
    ns      = norm3_r;
    st      = 1'b0;
    if (tiny) begin
      if (rs_full > 14'd63) begin
        ns = '0;
        st = 1'b1;
      end else begin
        ns = norm3_r >> rs_full[5:0];
        st = |(norm3_r & ~({64{1'b1}} << rs_full[5:0]));
      end
    end
    mant   = ns[63:11];
    rbit   = ns[10];
    inc    = rbit & (st | (|ns[9:0]) | mant[0]);
    efield = tiny ? 11'd0 : 11'(be3_r - 14'sd1);
    // The hidden bit adds into the exponent field, so a rounding carry moves it on.
    enc    = {1'b0, efield, 52'b0} + {11'b0, mant} + {63'b0, inc};
    if (sp3_r) begin
      res_nxt = spv3_r;
    end else if (ovf) begin
      res_nxt = {sgn3_r, EXP_MAX, 52'b0};
    end else begin
      res_nxt = {sgn3_r, enc[62:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_o.valid <= 1'b0;
    end else if (en) begin
      tag_o.valid <= tag3_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_o.act  <= tag3_r.act;
      tag_o.mask <= tag3_r.mask;
      res_o      <= res_nxt;
    end
  end

endmodule

[rtl/core/sensor_frame_field_extractor.sv]
// Top level of the sensor frame field extractor.
//
// Usage: one packet, reduced to its marker bytes, response word, first eight
// payload bytes and payload length, arrives per in_ch transaction. A header
// packet latches the response code and restarts the slot count; data packets
// advance it. While the latched code matches the configured measurement code,
// slots 2, 4 and 5 latch the phase, the temperature (minus 273.15) and the
// pressure (times 100), and slot 6 emits one record on out_ch.
// cfg_ch writes the 16-bit measurement code; it is always ready.
// Path: a record appears on out_ch once the slot 6 packet has passed the
// input register, decode, a three-stage float pipeline (align and add or
// multiply by 25, normalise, round) and the output register.
// Throughput: one packet per cycle while out_ch does not stall.
// Reset clears the slot count, the header flag and the latched values, and
// sets the measurement code to 17. When the receiver stalls a waiting record,
// the whole pipeline holds and in_ch.ready falls until the record is taken.
module sensor_frame_field_extractor
  import sffe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sffe_in_if.sink    in_ch,
  sffe_out_if.source out_ch,
  sffe_cfg_if.sink   cfg_ch
);

  logic en;
  logic out_valid_r;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  logic [15:0] measure_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measure_r <= MEASURE_RESET;
    end else if (cfg_ch.valid) begin
      measure_r <= cfg_ch.data;
    end
  end

  // Input register.
  logic        v0_r;
  logic [7:0]  marker_r, kind_r, len_r;
  logic [15:0] resp_r;
  logic [63:0] payload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_ch.valid) begin
      marker_r  <= in_ch.marker_byte;
      kind_r    <= in_ch.kind_byte;
      resp_r    <= in_ch.response_word;
      payload_r <= in_ch.payload;
      len_r     <= in_ch.payload_len;
    end
  end

  // Decode and slot tracking.
  logic [15:0] mode_r;
  logic        seen_r;
  logic [2:0]  slot_r, slot_nxt;
  logic        is_hdr, is_data, use_it, act_ok;
  act_t        act_nxt;
  tag_t        tag1_nxt, tag1_r;
  logic [63:0] x1_r;

  always_comb begin
    is_hdr   = (marker_r == PKT_MARKER) && (kind_r == KIND_HEADER);
    is_data  = (marker_r == PKT_MARKER) && (kind_r == KIND_DATA);
    slot_nxt = (slot_r == SLOT_LAST) ? 3'd0 : slot_r + 3'd1;
    use_it   = seen_r && (mode_r == measure_r);
    act_ok   = 1'b1;
    act_nxt  = ACT_PHASE;
    unique case (slot_nxt)
      SLOT_PHASE: act_nxt = ACT_PHASE;
      SLOT_TEMP:  act_nxt = ACT_TEMP;
      SLOT_PRES:  act_nxt = ACT_PRES;
      SLOT_ERR:   act_nxt = ACT_ERR;
      default:    act_ok  = 1'b0;
    endcase
    tag1_nxt.valid = v0_r && is_data && use_it && act_ok;
    tag1_nxt.act   = act_nxt;
    tag1_nxt.mask  = (len_r == LEN_MASK) ? payload_r[31:0] : MASK_BAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_CODE_RESET;
      seen_r       <= 1'b0;
      slot_r       <= '0;
      tag1_r.valid <= 1'b0;
    end else if (en) begin
      tag1_r.valid <= tag1_nxt.valid;
      if (v0_r && is_hdr) begin
        mode_r <= resp_r;
        seen_r <= 1'b1;
        slot_r <= '0;
      end else if (v0_r && is_data) begin
        slot_r <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r.act  <= tag1_nxt.act;
      tag1_r.mask <= tag1_nxt.mask;
      x1_r        <= (len_r == LEN_DOUBLE) ? payload_r : DBL_MINUS_ONE;
    end
  end

  tag_t        tag4;
  logic [63:0] res4;

  sffe_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag1_r),
    .x_i   (x1_r),
    .tag_o (tag4),
    .res_o (res4)
  );

  // Latched values and the output register. Items reach here in order, so a
  // record sees every update made by the packets before it.
  logic [63:0] phase_r, temp_r, pres_r;
  logic [63:0] o_phase_r, o_temp_r, o_pres_r;
  logic [31:0] o_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      temp_r      <= '0;
      pres_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag4.valid && (tag4.act == ACT_ERR);
      if (tag4.valid) begin
        unique case (tag4.act)
          ACT_PHASE: phase_r <= res4;
          ACT_TEMP:  temp_r  <= res4;
          ACT_PRES:  pres_r  <= res4;
          ACT_ERR:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_phase_r <= phase_r;
      o_temp_r  <= temp_r;
      o_pres_r  <= pres_r;
      o_mask_r  <= tag4.mask;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.phase_value   = o_phase_r;
  assign out_ch.temperature_c = o_temp_r;
  assign out_ch.pressure_pa   = o_pres_r;
  assign out_ch.error_mask    = o_mask_r;

endmodule

[rtl/core/sffe_checker.sv]
// Port-level checker for the sensor frame field extractor, with its bind.
module sffe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_phase,
  input logic [31:0] out_mask
);

  // A stalled record holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase) && $stable(out_mask))
    else $error("stalled record changed");

  // The pipeline freezes while a record waits, so no new transaction is taken.
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // The input side is open whenever the output register is empty.
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Reset leaves no record pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("record pending after reset");

endmodule

bind sensor_frame_field_extractor sffe_checker u_sffe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_phase (out_ch.phase_value),
  .out_mask  (out_ch.error_mask)
);
